>>> hdl/tuncls_pkg.sv
// Shared types, constants and helpers for the VLAN/IPv4/UDP tunnel classifier.
`timescale 1ns / 1ps
`default_nettype none

package tuncls_pkg;

  localparam int LENGTH_BITS_DEF      = 16;
  localparam int QUEUE_DEPTH_LOG2_DEF = 1;

  localparam int ETH_HDR_BYTES = 14;
  localparam int TYPE_POS_HI   = 12;
  localparam int TYPE_POS_LO   = 13;
  localparam int IP_MIN_BYTES  = 20;
  localparam int UDP_HDR_BYTES = 8;

  localparam logic [15:0] TPID_CTAG      = 16'h8100;
  localparam logic [15:0] TPID_STAG      = 16'h88a8;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;

  // Configuration space: three 32-bit registers at byte offsets 0, 4 and 8.
  localparam int CFG_ADDR_W = 4;
  localparam logic [1:0] REG_OWN_PORT    = 2'd0;
  localparam logic [1:0] REG_PEER_IP     = 2'd1;
  localparam logic [1:0] REG_REMOTE_PORT = 2'd2;

  typedef struct packed {
    logic [15:0] own_port;
    logic [31:0] peer_ip;
    logic [15:0] remote_port;
  } tuncls_cfg_t;

  // Header fields captured from one frame, handed from the parser to the matcher.
  typedef struct packed {
    logic [15:0] type_word;
    logic [5:0]  header_len;
    logic [7:0]  ip_protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
  } tuncls_frame_t;

  function automatic logic is_tag_type(input logic [15:0] t);
    return (t == TPID_CTAG) || (t == TPID_STAG);
  endfunction

endpackage

`default_nettype wire

>>> hdl/tuncls_regs.sv
// Configuration register file with an APB-style access port.
`timescale 1ns / 1ps
`default_nettype none

module tuncls_regs
  import tuncls_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready,
  output tuncls_cfg_t                cfg
);

  tuncls_cfg_t cfg_r, cfg_nxt;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_OWN_PORT:    cfg_nxt.own_port    = pwdata[15:0];
        REG_PEER_IP:     cfg_nxt.peer_ip     = pwdata;
        REG_REMOTE_PORT: cfg_nxt.remote_port = pwdata[15:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_OWN_PORT:    prdata = {16'h0000, cfg_r.own_port};
      REG_PEER_IP:     prdata = cfg_r.peer_ip;
      REG_REMOTE_PORT: prdata = {16'h0000, cfg_r.remote_port};
      default:         prdata = 32'h0000_0000;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> hdl/tuncls_front.sv
// Byte-serial header parser: walks Ethernet, VLAN tags, IPv4 and UDP port fields.
`timescale 1ns / 1ps
`default_nettype none

module tuncls_front
  import tuncls_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   accept,
  input  wire logic [7:0]             data,
  input  wire logic                   last,
  output logic                        push,
  output tuncls_frame_t               frame,
  output logic      [LENGTH_BITS-1:0] frame_len,
  output logic      [LENGTH_BITS-1:0] frame_l3
);

  localparam int LB = LENGTH_BITS;
  localparam logic [LB-1:0] COUNT_MAX = {LB{1'b1}};

  logic [LB-1:0] cnt_r, cnt_nxt;
  logic [LB-1:0] l3_r, l3_nxt;
  logic [7:0]    tag_byte_r, tag_byte_nxt;
  logic          in_tags_r, in_tags_nxt;
  tuncls_frame_t hdr_r, hdr_nxt;

  logic [LB-1:0] rel;
  logic [LB-1:0] port_off;
  logic [15:0]   tag_type;

  always_comb begin
    cnt_nxt      = cnt_r;
    l3_nxt       = l3_r;
    tag_byte_nxt = tag_byte_r;
    in_tags_nxt  = in_tags_r;
    hdr_nxt      = hdr_r;
    rel          = cnt_r - l3_r;
    port_off     = rel - LB'(hdr_r.header_len);
    tag_type     = {tag_byte_r, data};

    // Once the count saturates the rest of the frame is not parsed.
    if (cnt_r != COUNT_MAX) begin
      cnt_nxt = cnt_r + LB'(1);
      if (cnt_r == LB'(TYPE_POS_HI)) begin
        hdr_nxt.type_word = {data, 8'h00};
      end else if (cnt_r == LB'(TYPE_POS_LO)) begin
        hdr_nxt.type_word = {hdr_r.type_word[15:8], data};
        in_tags_nxt       = is_tag_type({hdr_r.type_word[15:8], data});
      end else if (cnt_r >= l3_r) begin
        if (in_tags_r) begin
          if (rel == LB'(2)) begin
            tag_byte_nxt = data;
          end else if (rel == LB'(3)) begin
            hdr_nxt.type_word = tag_type;
            l3_nxt            = l3_r + LB'(4);
            in_tags_nxt       = is_tag_type(tag_type);
          end
        end else begin
          if (rel == '0) begin
            hdr_nxt.header_len = {data[3:0], 2'b00};
          end else if (rel == LB'(9)) begin
            hdr_nxt.ip_protocol = data;
          end else if (rel >= LB'(12) && rel < LB'(16)) begin
            hdr_nxt.src_addr = {hdr_r.src_addr[23:0], data};
          end else if (rel >= LB'(16) && rel < LB'(20)) begin
            hdr_nxt.dst_addr = {hdr_r.dst_addr[23:0], data};
          end
          // The header length is still zero on the byte that sets it, so the
          // registered value gives the same answer as the updated one.
          if (hdr_r.header_len >= 6'(IP_MIN_BYTES) && rel >= LB'(hdr_r.header_len) &&
              port_off < LB'(4)) begin
            if (port_off < LB'(2)) begin
              hdr_nxt.src_port = {hdr_r.src_port[7:0], data};
            end else begin
              hdr_nxt.dst_port = {hdr_r.dst_port[7:0], data};
            end
          end
        end
      end
    end
  end

  assign push      = accept && last;
  assign frame     = hdr_nxt;
  assign frame_len = cnt_nxt;
  assign frame_l3  = l3_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      cnt_r      <= '0;
      l3_r       <= LB'(ETH_HDR_BYTES);
      tag_byte_r <= '0;
      in_tags_r  <= 1'b0;
      hdr_r      <= '0;
    end else if (accept) begin
      cnt_r      <= cnt_nxt;
      l3_r       <= l3_nxt;
      tag_byte_r <= tag_byte_nxt;
      in_tags_r  <= in_tags_nxt;
      hdr_r      <= hdr_nxt;
    end
  end

  // The L3 offset only ever moves in whole four-byte tags from fourteen.
  a_l3_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (l3_r >= LB'(ETH_HDR_BYTES)) && (l3_r[1:0] == 2'b10))
    else $error("L3 offset left the tag grid");

  // A final byte always leaves the parser ready for a fresh frame.
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (cnt_r == '0) && !in_tags_r)
    else $error("frame state not cleared after final byte");

endmodule

`default_nettype wire

>>> hdl/tuncls_queue.sv
// Small request queue between the parser and the tunnel matcher.
`timescale 1ns / 1ps
`default_nettype none

module tuncls_queue
  import tuncls_pkg::*;
#(
  parameter int WIDTH       = 8,
  parameter int DEPTH_LOG2  = QUEUE_DEPTH_LOG2_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  full,
  output logic                  not_empty
);

  localparam int DEPTH = 1 << DEPTH_LOG2;

  logic [WIDTH-1:0]    slot_r [DEPTH];
  logic [DEPTH_LOG2:0] wr_ptr_r, wr_ptr_nxt;
  logic [DEPTH_LOG2:0] rd_ptr_r, rd_ptr_nxt;
  logic [DEPTH_LOG2:0] level;

  assign level      = wr_ptr_r - rd_ptr_r;
  assign full       = level[DEPTH_LOG2];
  assign not_empty  = level != '0;
  assign rdata      = slot_r[rd_ptr_r[DEPTH_LOG2-1:0]];
  assign wr_ptr_nxt = wr_ptr_r + (DEPTH_LOG2 + 1)'(push);
  assign rd_ptr_nxt = rd_ptr_r + (DEPTH_LOG2 + 1)'(pop);

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r[DEPTH_LOG2-1:0]] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("request pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !not_empty))
    else $error("request popped from an empty queue");

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level <= (DEPTH_LOG2 + 1)'(DEPTH))
    else $error("queue level out of range");

endmodule

`default_nettype wire

>>> hdl/tuncls_back.sv
// Frame checks and tunnel port/address match, ending in the result register.
`timescale 1ns / 1ps
`default_nettype none

module tuncls_back
  import tuncls_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   req_valid,
  input  wire tuncls_frame_t          frame,
  input  wire logic [LENGTH_BITS-1:0] frame_len,
  input  wire logic [LENGTH_BITS-1:0] frame_l3,
  input  wire tuncls_cfg_t            cfg,
  output logic                        req_pop,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic      [15:0]            out_ethertype,
  output logic      [31:0]            out_ipv4_dst,
  output logic                        out_tunnel_match
);

  localparam int SW = LENGTH_BITS + 1;

  logic          valid_r, valid_nxt;
  logic [15:0]   ethertype_r, ethertype_nxt;
  logic [31:0]   ipv4_dst_r, ipv4_dst_nxt;
  logic          tunnel_r, tunnel_nxt;

  logic          load;
  logic [SW-1:0] len_ext;
  logic [SW-1:0] ip_end;
  logic [SW-1:0] udp_end;
  logic          ip_ok;
  logic          udp_ok;
  logic          ports_ok;
  logic          addr_ok;

  assign load    = !valid_r || !out_stall;
  assign req_pop = req_valid && load;

  assign len_ext = {1'b0, frame_len};
  assign ip_end  = {1'b0, frame_l3} + SW'(IP_MIN_BYTES);
  assign udp_end = {1'b0, frame_l3} + SW'(frame.header_len) + SW'(UDP_HDR_BYTES);

  always_comb begin
    ethertype_nxt = (frame_len >= LENGTH_BITS'(ETH_HDR_BYTES)) ? frame.type_word : 16'h0000;
    ip_ok  = (ethertype_nxt == ETHERTYPE_IPV4) && (len_ext >= ip_end) &&
             (frame.header_len >= 6'(IP_MIN_BYTES));
    udp_ok = ip_ok && (len_ext >= udp_end) && (frame.ip_protocol == PROTO_UDP);
    // A zero remote port accepts the own port on either side of the flow.
    if (cfg.remote_port != 16'h0000) begin
      ports_ok = (frame.src_port == cfg.remote_port && frame.dst_port == cfg.own_port) ||
                 (frame.src_port == cfg.own_port && frame.dst_port == cfg.remote_port);
    end else begin
      ports_ok = (frame.src_port == cfg.own_port) || (frame.dst_port == cfg.own_port);
    end
    addr_ok = (cfg.peer_ip == 32'h0000_0000) || (frame.src_addr == cfg.peer_ip) ||
              (frame.dst_addr == cfg.peer_ip);
    ipv4_dst_nxt = ip_ok ? frame.dst_addr : 32'h0000_0000;
    tunnel_nxt   = udp_ok && ports_ok && addr_ok;
    valid_nxt    = load ? req_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req_pop) begin
      ethertype_r <= ethertype_nxt;
      ipv4_dst_r  <= ipv4_dst_nxt;
      tunnel_r    <= tunnel_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign out_ethertype    = ethertype_r;
  assign out_ipv4_dst     = ipv4_dst_r;
  assign out_tunnel_match = tunnel_r;

  // A tunnel hit implies the frame was accepted as IPv4 with a destination.
  a_match_implies_ipv4: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && tunnel_r) |-> (ethertype_r == ETHERTYPE_IPV4))
    else $error("tunnel match on a non-IPv4 result");

endmodule

`default_nettype wire

>>> hdl/vlan_ipv4_udp_tunnel_classifier_unit.sv
// Top level of the VLAN/IPv4/UDP tunnel classifier.
//
//   Channel  Direction  Handshake              Payload
//   in_      input      in_valid / in_stall    in_data[7:0], in_last
//   out_     output     out_valid / out_stall  out_ethertype[15:0], out_ipv4_dst[31:0],
//                                              out_tunnel_match
//   config   input      psel / penable / pready  paddr[3:0], pwdata[31:0], prdata[31:0]
//
// One frame byte is taken every clock while in_stall is low; the parser loops on its state.
// The request of a frame is written into the queue when its final byte is taken, and the
// result is presented once the request loads the matcher's output register; a stalled
// output holds the request in the queue until the output register is free.
// rst_n is synchronous; it clears the parser, the queue, the result valid and the registers.
// in_stall rises only while the request queue is full, which needs a stalled output and
// more completed frames than the queue holds.
`timescale 1ns / 1ps
`default_nettype none

module vlan_ipv4_udp_tunnel_classifier_unit
  import tuncls_pkg::*;
#(
  parameter int LENGTH_BITS      = LENGTH_BITS_DEF,
  parameter int QUEUE_DEPTH_LOG2 = QUEUE_DEPTH_LOG2_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [7:0]            in_data,
  input  wire logic                  in_last,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [15:0]           out_ethertype,
  output logic      [31:0]           out_ipv4_dst,
  output logic                       out_tunnel_match,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready
);

  localparam int FRAME_W = $bits(tuncls_frame_t);
  localparam int REQ_W   = FRAME_W + 2 * LENGTH_BITS;

  tuncls_cfg_t              cfg;
  logic                     accept;
  logic                     push;
  tuncls_frame_t            frame_in;
  logic [LENGTH_BITS-1:0]   len_in;
  logic [LENGTH_BITS-1:0]   l3_in;
  logic [REQ_W-1:0]         req_wdata;
  logic [REQ_W-1:0]         req_rdata;
  logic                     req_full;
  logic                     req_valid;
  logic                     req_pop;
  tuncls_frame_t            frame_out;
  logic [LENGTH_BITS-1:0]   len_out;
  logic [LENGTH_BITS-1:0]   l3_out;

  assign in_stall  = req_full;
  assign accept    = in_valid && !req_full;
  assign req_wdata = {len_in, l3_in, frame_in};
  assign {len_out, l3_out, frame_out} = req_rdata;

  tuncls_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tuncls_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data      (in_data),
    .last      (in_last),
    .push      (push),
    .frame     (frame_in),
    .frame_len (len_in),
    .frame_l3  (l3_in)
  );

  tuncls_queue #(
    .WIDTH      (REQ_W),
    .DEPTH_LOG2 (QUEUE_DEPTH_LOG2)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wdata     (req_wdata),
    .pop       (req_pop),
    .rdata     (req_rdata),
    .full      (req_full),
    .not_empty (req_valid)
  );

  tuncls_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req_valid),
    .frame            (frame_out),
    .frame_len        (len_out),
    .frame_l3         (l3_out),
    .cfg              (cfg),
    .req_pop          (req_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_ethertype    (out_ethertype),
    .out_ipv4_dst     (out_ipv4_dst),
    .out_tunnel_match (out_tunnel_match)
  );

endmodule

`default_nettype wire
